### hdl/single_wire_sensor_reader_top_assert.svh
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_top_assert
// assertion macros used by the sensor reader checker
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_READER_TOP_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_READER_TOP_ASSERT_SVH

// same-cycle implication
`define SWSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// types and constants of the single-wire sensor reader
// ----------------------------------------------------------------------------
package swsr_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int REQ_W         = 15;
    localparam int DELAY_W       = 7;
    localparam int FRAME_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int BIT_IDX_W     = 3;
    localparam int BYTE_IDX_W    = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES  = 2'd2;

    localparam logic [REQ_W-1:0]   RST_REQUEST_LOW  = 15'd20000;
    localparam logic [DELAY_W-1:0] RST_SAMPLE_DELAY = 7'd30;
    localparam logic [FRAME_W-1:0] RST_FRAME_BYTES  = 4'd5;
    localparam logic [FRAME_W-1:0] FRAME_MIN        = 4'd1;
    localparam logic [FRAME_W-1:0] FRAME_MAX        = 4'd8;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT       = 3'(BITS_PER_BYTE - 1);

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_REQUEST   = 8'b0000_0010,
        PH_RESP_LOW  = 8'b0000_0100,
        PH_RESP_HIGH = 8'b0000_1000,
        PH_RESP_END  = 8'b0001_0000,
        PH_BIT_HIGH  = 8'b0010_0000,
        PH_BIT_DELAY = 8'b0100_0000,
        PH_BIT_FALL  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic cmd;
        logic line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic [7:0] byte_value;
        logic       byte_valid;
        logic       last_byte;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

### hdl/swsr_in_stage.sv
// ----------------------------------------------------------------------------
// swsr_in_stage
// input register holding one accepted item
// ----------------------------------------------------------------------------
module swsr_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  swsr_pkg::t_item i_item,
    output logic            o_valid,
    output swsr_pkg::t_item o_item,
    input  logic            i_ready
);

    logic            r_valid;
    swsr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### hdl/swsr_core.sv
// ----------------------------------------------------------------------------
// swsr_core
// protocol state machine, timer, bit and byte counters, config registers
// ----------------------------------------------------------------------------
module swsr_core #(
    parameter int TIMER_WIDTH = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swsr_pkg::t_cfg_wr i_cfg,
    input  logic              i_step,
    input  swsr_pkg::t_item   i_item,
    output swsr_pkg::t_result o_result
);

    localparam int CMP_W = (TIMER_WIDTH > swsr_pkg::REQ_W) ? TIMER_WIDTH : swsr_pkg::REQ_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    logic [swsr_pkg::REQ_W-1:0]      r_req_low;
    logic [swsr_pkg::DELAY_W-1:0]    r_delay;
    logic [swsr_pkg::FRAME_W-1:0]    r_frame;

    swsr_pkg::t_phase                r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]          r_tick, n_tick;
    logic [swsr_pkg::BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [swsr_pkg::BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]                      r_shift, n_shift;

    logic [TIMER_WIDTH-1:0]          tick_inc;
    logic                            req_done;
    logic                            delay_done;
    logic [7:0]                      shift_in;
    logic [swsr_pkg::FRAME_W-1:0]    frame_clamp;
    logic                            frame_end;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_low <= swsr_pkg::RST_REQUEST_LOW;
            r_delay   <= swsr_pkg::RST_SAMPLE_DELAY;
            r_frame   <= swsr_pkg::RST_FRAME_BYTES;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                swsr_pkg::REG_REQUEST_LOW: begin
                    r_req_low <= i_cfg.data[swsr_pkg::REQ_W-1:0];
                end
                swsr_pkg::REG_SAMPLE_DELAY: begin
                    r_delay <= i_cfg.data[swsr_pkg::DELAY_W-1:0];
                end
                swsr_pkg::REG_FRAME_BYTES: begin
                    r_frame <= i_cfg.data[swsr_pkg::FRAME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // saturating timer and limit checks
    assign tick_inc   = (r_tick == TMAX) ? r_tick : r_tick + 1'b1;
    assign req_done   = (CMP_W'(tick_inc) >= CMP_W'(r_req_low)) || (tick_inc == TMAX);
    assign delay_done = (CMP_W'(tick_inc) >= CMP_W'(r_delay)) || (tick_inc == TMAX);
    assign shift_in   = {r_shift[6:0], i_item.line_level};

    always_comb begin
        if (r_frame == '0) begin
            frame_clamp = swsr_pkg::FRAME_MIN;
        end else if (r_frame > swsr_pkg::FRAME_MAX) begin
            frame_clamp = swsr_pkg::FRAME_MAX;
        end else begin
            frame_clamp = r_frame;
        end
    end

    assign frame_end = ({1'b0, r_byte_idx} + 4'd1) >= frame_clamp;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        o_result   = '0;
        if (i_item.cmd) begin
            n_phase            = swsr_pkg::PH_REQUEST;
            n_tick             = '0;
            n_bit_idx          = '0;
            n_byte_idx         = '0;
            n_shift            = '0;
            o_result.drive_low = 1'b1;
        end else begin
            case (r_phase)
                swsr_pkg::PH_REQUEST: begin
                    n_tick = tick_inc;
                    if (req_done) begin
                        n_phase = swsr_pkg::PH_RESP_LOW;
                    end else begin
                        o_result.drive_low = 1'b1;
                    end
                end
                swsr_pkg::PH_RESP_LOW: begin
                    if (!i_item.line_level) begin
                        n_phase = swsr_pkg::PH_RESP_HIGH;
                    end
                end
                swsr_pkg::PH_RESP_HIGH: begin
                    if (i_item.line_level) begin
                        n_phase = swsr_pkg::PH_RESP_END;
                    end
                end
                swsr_pkg::PH_RESP_END: begin
                    if (!i_item.line_level) begin
                        n_phase = swsr_pkg::PH_BIT_HIGH;
                    end
                end
                swsr_pkg::PH_BIT_HIGH: begin
                    if (i_item.line_level) begin
                        n_tick  = '0;
                        n_phase = swsr_pkg::PH_BIT_DELAY;
                    end
                end
                swsr_pkg::PH_BIT_DELAY: begin
                    n_tick = tick_inc;
                    if (delay_done) begin
                        n_shift = shift_in;
                        n_phase = i_item.line_level ? swsr_pkg::PH_BIT_FALL
                                                    : swsr_pkg::PH_BIT_HIGH;
                        if (r_bit_idx == swsr_pkg::LAST_BIT) begin
                            o_result.byte_value = shift_in;
                            o_result.byte_valid = 1'b1;
                            n_shift             = '0;
                            n_bit_idx           = '0;
                            if (frame_end) begin
                                o_result.last_byte = 1'b1;
                                n_phase            = swsr_pkg::PH_IDLE;
                                n_byte_idx         = '0;
                            end else begin
                                n_byte_idx = r_byte_idx + 1'b1;
                            end
                        end else begin
                            n_bit_idx = r_bit_idx + 1'b1;
                        end
                    end
                end
                swsr_pkg::PH_BIT_FALL: begin
                    if (!i_item.line_level) begin
                        n_phase = swsr_pkg::PH_BIT_HIGH;
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.busy_res = (n_phase != swsr_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= swsr_pkg::PH_IDLE;
            r_tick     <= '0;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
            r_shift    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
        end
    end

endmodule

### hdl/swsr_out_reg.sv
// ----------------------------------------------------------------------------
// swsr_out_reg
// result register on the output stream
// ----------------------------------------------------------------------------
module swsr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  swsr_pkg::t_result i_result,
    output logic              o_valid,
    output swsr_pkg::t_result o_result,
    input  logic              i_ready
);

    logic              r_valid;
    swsr_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

### hdl/single_wire_sensor_reader_top.sv
// path: an input transfer is held in the input register, then its result in the result register
// throughput: one item per cycle while the output is not stalled, set by the single-pass
//   state update between the input register and the result register
// reset: synchronous active-low, restores register defaults, idle phase, empty stages
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_top
// single-wire humidity and temperature sensor master, one tick per item
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_top #(
    parameter int TIMER_WIDTH = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [swsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // line_level
    input  logic                               s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // drive_low, byte_value, busy_res
    output logic                               m_axis_tuser,  // byte_valid
    output logic                               m_axis_tlast   // last_byte
);

    swsr_pkg::t_item   w_in_item, w_st_item;
    swsr_pkg::t_result w_core_res, w_out_res;
    swsr_pkg::t_cfg_wr w_cfg;
    logic              w_st_valid;
    logic              w_out_ready;
    logic              w_step;

    assign w_in_item.cmd        = s_axis_tuser;
    assign w_in_item.line_level = s_axis_tdata[0];

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    assign w_step = w_st_valid && w_out_ready;

    swsr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_st_valid),
        .o_item  (w_st_item),
        .i_ready (w_out_ready)
    );

    swsr_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (w_st_item),
        .o_result (w_core_res)
    );

    swsr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_st_valid),
        .o_ready  (w_out_ready),
        .i_result (w_core_res),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_res),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, w_out_res.busy_res, w_out_res.byte_value,
                           w_out_res.drive_low};
    assign m_axis_tuser = w_out_res.byte_valid;
    assign m_axis_tlast = w_out_res.last_byte;

endmodule

### hdl/swsr_checker.sv
// ----------------------------------------------------------------------------
// swsr_checker
// port-level checks of the sensor reader, bound to the top level
// ----------------------------------------------------------------------------
`include "single_wire_sensor_reader_top_assert.svh"

module swsr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [swsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);

    // last byte of a frame ends the transaction
    `SWSR_ASSERT_IMP(a_last_ends, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser && !m_axis_tdata[9], "last byte without valid byte or still busy")

    // no byte means empty value and no last mark
    `SWSR_ASSERT_IMP(a_no_byte_empty, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[8:1] == 8'd0) && !m_axis_tlast, "stray byte data without valid byte")

    // the line is only pulled low inside a transaction
    `SWSR_ASSERT_IMP(a_drive_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[9], "drive low while not busy")

    // a stalled transfer holds
    `SWSR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind single_wire_sensor_reader_top swsr_checker u_swsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
